// ----- sv/trd_pkg.sv -----
// shared types and constants for the task ring deque
// used by trd_entry_ram, task_ring_deque and the testbench; no dependencies
package trd_pkg;

  localparam int DEPTH       = 32;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int GIVE_W      = $clog2(MAX_RESULTS + 1);
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 4 * WORD_W;
  localparam int IN_TDATA_W  = ENTRY_W;
  localparam int OUT_TDATA_W = ((ENTRY_W + CNT_W + 7) / 8) * 8;
  localparam int MODE_W      = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_TAIL = 3'd0,
    MODE_PUSH_HEAD = 3'd1,
    MODE_YIELD     = 3'd2,
    MODE_POP       = 3'd3,
    MODE_GIVE      = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_YCOPY,
    ST_YPUT,
    ST_DELIVER
  } state_t;

  // task_ref sits in the lowest bits
  typedef struct packed {
    logic [WORD_W-1:0] param_c;
    logic [WORD_W-1:0] param_b;
    logic [WORD_W-1:0] param_a;
    logic [WORD_W-1:0] task_ref;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- sv/trd_entry_ram.sv -----
// entry store of the task ring deque: one write port, one registered read port
// depends on trd_pkg
module trd_entry_ram (
  input  logic              clk,
  input  trd_pkg::mem_req_t req,
  input  trd_pkg::entry_t   wdata,
  output trd_pkg::entry_t   rdata
);

  trd_pkg::entry_t mem [trd_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- sv/task_ring_deque.sv -----
// top level of the task ring deque: control sequencer and output register
// depends on trd_pkg and trd_entry_ram
//
//  channel  dir  tdata                                  tuser     tlast
//  s_*      in   task_ref, param_a, param_b, param_c    mode      -
//  m_*      out  task_ref, param_a, param_b, param_c,   ok        last
//                fill_after
//
// one request at a time; give hands out half the entries, rounded up, at most MAX_RESULTS
// push, a failed request or a yield on an empty deque answer straight from ST_EXEC;
// pop and give read the ram first, yield reads the old head and copies it one slot forward
// a stalled output holds the sequencer; s_tready is high only when idle
// rst clears head, fill and control; the entry ram has no reset
module task_ring_deque (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [trd_pkg::IN_TDATA_W-1:0]  s_tdata,   // task_ref, param_a, param_b, param_c
  input  logic [trd_pkg::MODE_W-1:0]      s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [trd_pkg::OUT_TDATA_W-1:0] m_tdata,   // task_ref, param_a/b/c, fill_after
  output logic                            m_tuser,   // ok
  output logic                            m_tlast
);

  trd_pkg::state_t state, state_next;
  trd_pkg::mode_t  mode;
  trd_pkg::entry_t item;
  trd_pkg::entry_t rdata;
  trd_pkg::entry_t wdata;
  trd_pkg::mem_req_t req;

  logic [trd_pkg::IDX_W-1:0]  head, head_next;
  logic [trd_pkg::CNT_W-1:0]  fill, fill_next;
  logic [trd_pkg::GIVE_W-1:0] remaining, remaining_next;

  logic                       out_ok;
  logic                       out_last;
  logic [trd_pkg::CNT_W-1:0]  out_fill;
  trd_pkg::entry_t            out_entry;

  logic                       emit, emit_ok, emit_mem, emit_last;
  logic [trd_pkg::CNT_W-1:0]  emit_fill;
  logic                       out_free;
  logic                       full;
  logic [trd_pkg::IDX_W-1:0]  prev_idx, next_idx, tail_idx;
  logic [trd_pkg::CNT_W:0]    tail_sum;
  logic [trd_pkg::CNT_W:0]    half;
  logic [trd_pkg::GIVE_W-1:0] give_amt;
  logic [trd_pkg::CNT_W-1:0]  fill_inc, fill_dec;

  trd_entry_ram u_ram (
    .clk   (clk),
    .req   (req),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign s_tready = (state == trd_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (fill == trd_pkg::CNT_W'(trd_pkg::DEPTH));
  assign fill_inc = fill + 1'b1;
  assign fill_dec = fill - 1'b1;

  assign prev_idx = (head == '0) ? trd_pkg::IDX_W'(trd_pkg::DEPTH - 1) : head - 1'b1;
  assign next_idx = (head == trd_pkg::IDX_W'(trd_pkg::DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = (trd_pkg::CNT_W + 1)'(head) + (trd_pkg::CNT_W + 1)'(fill);
  assign tail_idx = (tail_sum >= (trd_pkg::CNT_W + 1)'(trd_pkg::DEPTH)) ?
                    trd_pkg::IDX_W'(tail_sum - (trd_pkg::CNT_W + 1)'(trd_pkg::DEPTH)) :
                    trd_pkg::IDX_W'(tail_sum);
  assign half     = ((trd_pkg::CNT_W + 1)'(fill) + 1'b1) >> 1;
  assign give_amt = (half > (trd_pkg::CNT_W + 1)'(trd_pkg::MAX_RESULTS)) ?
                    trd_pkg::GIVE_W'(trd_pkg::MAX_RESULTS) : trd_pkg::GIVE_W'(half);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trd_pkg::ST_IDLE;
      head      <= '0;
      fill      <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      fill      <= fill_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_tdata;
      mode <= trd_pkg::mode_t'(s_tuser);
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    fill_next      = fill;
    remaining_next = remaining;
    req            = '0;
    wdata          = item;
    emit           = 1'b0;
    emit_ok        = 1'b0;
    emit_mem       = 1'b0;
    emit_last      = 1'b1;
    emit_fill      = fill;
    unique case (state)
      trd_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = trd_pkg::ST_EXEC;
        end
      end
      trd_pkg::ST_EXEC: begin
        unique case (mode)
          trd_pkg::MODE_PUSH_TAIL: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = trd_pkg::ST_IDLE;
              if (!full) begin
                req.we    = 1'b1;
                req.waddr = tail_idx;
                fill_next = fill_inc;
                emit_ok   = 1'b1;
                emit_fill = fill_inc;
              end
            end
          end
          trd_pkg::MODE_PUSH_HEAD, trd_pkg::MODE_YIELD: begin
            if (mode == trd_pkg::MODE_YIELD && !full && fill != '0) begin
              req.re     = 1'b1;
              req.raddr  = head;
              state_next = trd_pkg::ST_YCOPY;
            end else if (out_free) begin
              emit       = 1'b1;
              state_next = trd_pkg::ST_IDLE;
              if (!full) begin
                req.we    = 1'b1;
                req.waddr = prev_idx;
                head_next = prev_idx;
                fill_next = fill_inc;
                emit_ok   = 1'b1;
                emit_fill = fill_inc;
              end
            end
          end
          trd_pkg::MODE_POP, trd_pkg::MODE_GIVE: begin
            if (fill == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                state_next = trd_pkg::ST_IDLE;
                if (mode == trd_pkg::MODE_POP) begin
                  head_next = '0;
                end
              end
            end else begin
              req.re         = 1'b1;
              req.raddr      = head;
              remaining_next = (mode == trd_pkg::MODE_POP) ? trd_pkg::GIVE_W'(1) : give_amt;
              state_next     = trd_pkg::ST_DELIVER;
            end
          end
          default: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = trd_pkg::ST_IDLE;
            end
          end
        endcase
      end
      trd_pkg::ST_YCOPY: begin
        // old head moves one slot toward the front
        req.we     = 1'b1;
        req.waddr  = prev_idx;
        wdata      = rdata;
        state_next = trd_pkg::ST_YPUT;
      end
      trd_pkg::ST_YPUT: begin
        if (out_free) begin
          req.we     = 1'b1;
          req.waddr  = head;
          head_next  = prev_idx;
          fill_next  = fill_inc;
          emit       = 1'b1;
          emit_ok    = 1'b1;
          emit_fill  = fill_inc;
          state_next = trd_pkg::ST_IDLE;
        end
      end
      trd_pkg::ST_DELIVER: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_ok        = 1'b1;
          emit_mem       = 1'b1;
          emit_fill      = fill_dec;
          emit_last      = (remaining == trd_pkg::GIVE_W'(1));
          head_next      = next_idx;
          fill_next      = fill_dec;
          remaining_next = remaining - 1'b1;
          if (remaining == trd_pkg::GIVE_W'(1)) begin
            state_next = trd_pkg::ST_IDLE;
          end else begin
            req.re    = 1'b1;
            req.raddr = next_idx;
          end
        end
      end
      default: begin
        state_next = trd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ok    <= emit_ok;
      out_last  <= emit_last;
      out_fill  <= emit_fill;
      out_entry <= emit_mem ? rdata : '0;
    end
  end

  assign m_tdata = trd_pkg::OUT_TDATA_W'({out_fill, out_entry});
  assign m_tuser = out_ok;
  assign m_tlast = out_last;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= trd_pkg::CNT_W'(trd_pkg::DEPTH))
    else $error("fill count above capacity");

  a_deliver_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == trd_pkg::ST_DELIVER |-> remaining != '0 && fill != '0)
    else $error("delivering with nothing left");

  a_deliver_dec: assert property (@(posedge clk) disable iff (rst)
    state == trd_pkg::ST_DELIVER && out_free |=> fill == $past(fill_dec))
    else $error("delivered entry did not leave the deque");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwrote a waiting result");

  a_ycopy_then_put: assert property (@(posedge clk) disable iff (rst)
    state == trd_pkg::ST_YCOPY |=> state == trd_pkg::ST_YPUT)
    else $error("yield sequence broken");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for task_ring_deque: directed and random requests over
// both stream ports, each result checked against a behavioral mirror of the deque
// depends on trd_pkg and task_ring_deque
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEND_IDLE[4]  = '{0, 55, 0, 18};
  localparam int RECV_STALL[4] = '{0, 0, 55, 18};

  typedef struct {
    logic                      ok;
    trd_pkg::entry_t           ent;
    logic                      last;
    logic [trd_pkg::CNT_W-1:0] fill_after;
  } delivery_t;

  class deque_mirror;
    trd_pkg::entry_t slot_entry[trd_pkg::DEPTH];
    int              head_slot;
    int              fill;
    delivery_t       awaited[$];
    int              mismatches;

    function new();
      head_slot  = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    function void apply_request(logic [trd_pkg::MODE_W-1:0] md, trd_pkg::entry_t e);
      delivery_t d;
      int give;
      int nh;
      d.ok   = 1'b0;
      d.ent  = '0;
      d.last = 1'b1;
      case (md)
        trd_pkg::MODE_PUSH_TAIL: begin
          if (fill < trd_pkg::DEPTH) begin
            slot_entry[(head_slot + fill) % trd_pkg::DEPTH] = e;
            fill++;
            d.ok = 1'b1;
          end
        end
        trd_pkg::MODE_PUSH_HEAD, trd_pkg::MODE_YIELD: begin
          if (fill < trd_pkg::DEPTH) begin
            nh = (head_slot + trd_pkg::DEPTH - 1) % trd_pkg::DEPTH;
            // yield keeps the current head in front
            if (md == trd_pkg::MODE_YIELD && fill != 0) begin
              slot_entry[nh]        = slot_entry[head_slot];
              slot_entry[head_slot] = e;
            end else begin
              slot_entry[nh] = e;
            end
            head_slot = nh;
            fill++;
            d.ok = 1'b1;
          end
        end
        trd_pkg::MODE_POP: begin
          if (fill == 0) begin
            head_slot = 0;
          end else begin
            d.ok      = 1'b1;
            d.ent     = slot_entry[head_slot];
            head_slot = (head_slot + 1) % trd_pkg::DEPTH;
            fill--;
          end
        end
        trd_pkg::MODE_GIVE: begin
          if (fill != 0) begin
            give = (fill + 1) >> 1;
            if (give > trd_pkg::MAX_RESULTS) give = trd_pkg::MAX_RESULTS;
            for (int k = 0; k < give; k++) begin
              d.ok         = 1'b1;
              d.ent        = slot_entry[head_slot];
              head_slot    = (head_slot + 1) % trd_pkg::DEPTH;
              fill--;
              d.last       = (k == give - 1);
              d.fill_after = trd_pkg::CNT_W'(fill);
              awaited.push_back(d);
            end
            return;
          end
        end
        default: begin
        end
      endcase
      d.fill_after = trd_pkg::CNT_W'(fill);
      awaited.push_back(d);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_delivery(logic ok, logic last,
                                 logic [trd_pkg::OUT_TDATA_W-1:0] data);
      delivery_t                 want;
      trd_pkg::entry_t           got_ent;
      logic [trd_pkg::CNT_W-1:0] got_fill;
      got_ent  = data[trd_pkg::ENTRY_W-1:0];
      got_fill = data[trd_pkg::ENTRY_W +: trd_pkg::CNT_W];
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none got ok %b task_ref %h fill %0d",
                 $time, ok, got_ent.task_ref, got_fill);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      match_field("ok", 32'(want.ok), 32'(ok));
      match_field("task_ref", want.ent.task_ref, got_ent.task_ref);
      match_field("param_a", want.ent.param_a, got_ent.param_a);
      match_field("param_b", want.ent.param_b, got_ent.param_b);
      match_field("param_c", want.ent.param_c, got_ent.param_c);
      match_field("last", 32'(want.last), 32'(last));
      match_field("fill_after", 32'(want.fill_after), 32'(got_fill));
    endfunction
  endclass

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [trd_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [trd_pkg::MODE_W-1:0]      s_tuser  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [trd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;

  deque_mirror mirror = new();
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_request   = 1'b0;
  int  held           = 0;
  int  cycle_count    = 0;

  task_ring_deque dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL task_ring_deque");
      $finish;
    end
  end

  // request first, then result, so a prediction is always in place
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) mirror.apply_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) mirror.check_delivery(m_tuser, m_tlast, m_tdata);
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held = HOLD_CYCLES;
      end
      if (held > 0) begin
        held--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic trd_pkg::entry_t random_entry();
    trd_pkg::entry_t e;
    case ($urandom_range(9))
      0: e = '0;
      1: e = '1;
      default: begin
        e.task_ref = $urandom();
        e.param_a  = $urandom();
        e.param_b  = $urandom();
        e.param_c  = $urandom();
      end
    endcase
    return e;
  endfunction

  function automatic logic [trd_pkg::MODE_W-1:0] push_kind();
    case ($urandom_range(2))
      0: return trd_pkg::MODE_PUSH_TAIL;
      1: return trd_pkg::MODE_PUSH_HEAD;
      default: return trd_pkg::MODE_YIELD;
    endcase
  endfunction

  function automatic logic [trd_pkg::MODE_W-1:0] pick_mode(bit growing);
    int p;
    p = $urandom_range(99);
    if (growing) begin
      if (p < 90) return push_kind();
      return trd_pkg::MODE_W'($urandom_range(2 ** trd_pkg::MODE_W - 1));
    end
    if (p < 10) return push_kind();
    if (p < 50) return trd_pkg::MODE_POP;
    if (p < 85) return trd_pkg::MODE_GIVE;
    return trd_pkg::MODE_W'($urandom_range(2 ** trd_pkg::MODE_W - 1));
  endfunction

  // valid stays high between back-to-back requests
  task automatic send_request(input logic [trd_pkg::MODE_W-1:0] md,
                              input trd_pkg::entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= e;
    s_tuser  <= md;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int grow_len;
    int drain_len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty deque cases, then a short mix with extremes
    send_request(trd_pkg::MODE_POP, random_entry());
    send_request(trd_pkg::MODE_GIVE, random_entry());
    send_request(trd_pkg::MODE_YIELD, '1);
    send_request(trd_pkg::MODE_PUSH_TAIL, '0);
    send_request(trd_pkg::MODE_PUSH_HEAD, random_entry());
    send_request(trd_pkg::MODE_YIELD, random_entry());
    send_request(trd_pkg::MODE_PUSH_TAIL, '1);
    send_request(trd_pkg::MODE_GIVE, random_entry());
    send_request(trd_pkg::MODE_POP, random_entry());
    send_request(trd_pkg::MODE_POP, random_entry());
    send_request(trd_pkg::MODE_POP, random_entry());
    for (int m = trd_pkg::MODE_GIVE + 1; m < 2 ** trd_pkg::MODE_W; m++) begin
      send_request(trd_pkg::MODE_W'(m), '1);
    end
    send_request(trd_pkg::MODE_PUSH_TAIL, random_entry());
    send_request(trd_pkg::MODE_GIVE, random_entry());
    send_request(trd_pkg::MODE_GIVE, random_entry());

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      grow_len  = (ph == 0) ? 40 : $urandom_range(20, 36);
      drain_len = $urandom_range(6, 10);
      for (int k = 0; k < grow_len; k++) begin
        if (ph == 0 && k == 30) hold_request = 1'b1;
        send_request(pick_mode(1'b1), random_entry());
      end
      for (int k = 0; k < drain_len; k++) send_request(pick_mode(1'b0), random_entry());
    end

    s_tvalid <= 1'b0;
    // let the last accepted request reach the mirror
    @(posedge clk);
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("PASS task_ring_deque");
    end else begin
      $display("FAIL task_ring_deque");
    end
    $finish;
  end

endmodule
